FILE: design/vn_pkg.sv
// shared constants for the vector normalizer pipeline
// no dependencies
package vn_pkg;

    // unit components leave as signed q1.30
    localparam int UNIT_FRAC  = 30;
    localparam int UNIT_WIDTH = 32;
    // magnitude of one unit component before the sign is applied
    localparam int KW         = UNIT_FRAC + 1;

endpackage

FILE: design/vn_front.sv
// front end: component magnitudes, squares and the sum of squares
// depends on vn_pkg
module vn_front
    import vn_pkg::*;
#(
    parameter int CW = 32
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] z_in,
    output logic [2*CW+1:0]      sum_sq,
    output logic [2*CW-1:0]      sq [3],
    output logic [2:0]           sign
);

    logic [CW-1:0]   abs_reg [3];
    logic [CW-1:0]   abs_next [3];
    logic [2:0]      sign_a_reg;
    logic [2:0]      sign_b_reg;
    logic [2:0]      sign_c_reg;
    logic [2*CW-1:0] sq_reg [3];
    logic [2*CW-1:0] sq_c_reg [3];
    logic [2*CW+1:0] sum_reg;
    logic [2*CW+1:0] sum_next;
    logic [CW-1:0]   comp [3];

    assign comp[0] = x_in;
    assign comp[1] = y_in;
    assign comp[2] = z_in;

    // two's complement magnitude, most negative value wraps to its true size
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            abs_next[j] = comp[j][CW-1] ? (~comp[j] + CW'(1)) : comp[j];
        end
        sum_next = (2*CW+2)'(sq_reg[0]) + (2*CW+2)'(sq_reg[1]) + (2*CW+2)'(sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                abs_reg[j]    <= abs_next[j];
                sign_a_reg[j] <= comp[j][CW-1];
                sq_reg[j]     <= abs_reg[j] * abs_reg[j];
                sq_c_reg[j]   <= sq_reg[j];
            end
            sign_b_reg <= sign_a_reg;
            sign_c_reg <= sign_b_reg;
            sum_reg    <= sum_next;
        end
    end

    assign sum_sq = sum_reg;
    assign sq     = sq_c_reg;
    assign sign   = sign_c_reg;

endmodule

FILE: design/vn_step.sv
// one pipeline stage: one root bit and one bit of each unit component, where each bit exists
// depends on vn_pkg
module vn_step
    import vn_pkg::*;
#(
    parameter int CW = 32,
    parameter int B  = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [2*CW+1:0]      s_i,
    input  logic [2*CW+1:0]      rd_i,
    input  logic [CW+1:0]        r_i,
    input  logic [2*CW+58:0]     ud_i [3],
    input  logic [2*CW+32:0]     up_i [3],
    input  logic [KW-1:0]        k_i [3],
    input  logic [2:0]           sign_i,
    output logic [2*CW+1:0]      s_o,
    output logic [2*CW+1:0]      rd_o,
    output logic [CW+1:0]        r_o,
    output logic [2*CW+58:0]     ud_o [3],
    output logic [2*CW+32:0]     up_o [3],
    output logic [KW-1:0]        k_o [3],
    output logic [2:0]           sign_o
);

    localparam int SW  = 2*CW + 2;
    localparam int MW  = CW + 2;
    localparam int RTW = SW + MW + 1;
    localparam int UDW = 2*CW + 59;
    localparam int PW  = 2*CW + 33;
    localparam int UTW = PW + 32;

    logic [SW-1:0]  rd_next;
    logic [MW-1:0]  r_next;
    logic [UDW-1:0] ud_next [3];
    logic [PW-1:0]  up_next [3];
    logic [KW-1:0]  k_next [3];

    generate
        if (B < MW) begin : g_root
            logic [RTW-1:0] rterm;
            // restoring root: try r + 2^b against the remainder s - r^2
            always_comb begin
                rterm = (RTW'(r_i) << (B + 1)) + (RTW'(1) << (2 * B));
                if (rterm <= RTW'(rd_i)) begin
                    rd_next = SW'(RTW'(rd_i) - rterm);
                    r_next  = r_i | (MW'(1) << B);
                end else begin
                    rd_next = rd_i;
                    r_next  = r_i;
                end
            end
        end else begin : g_no_root
            assign rd_next = rd_i;
            assign r_next  = r_i;
        end

        if (B <= UNIT_FRAC) begin : g_unit
            logic [UTW-1:0] uterm [3];
            // largest k with k^2*s <= a^2*2^60, kept as d = bound - k^2*s, p = k*s
            always_comb begin
                for (int j = 0; j < 3; j++) begin
                    uterm[j] = (UTW'(up_i[j]) << (B + 1)) + (UTW'(s_i) << (2 * B));
                    if (uterm[j] <= UTW'(ud_i[j])) begin
                        ud_next[j] = UDW'(UTW'(ud_i[j]) - uterm[j]);
                        up_next[j] = up_i[j] + (PW'(s_i) << B);
                        k_next[j]  = k_i[j] | (KW'(1) << B);
                    end else begin
                        ud_next[j] = ud_i[j];
                        up_next[j] = up_i[j];
                        k_next[j]  = k_i[j];
                    end
                end
            end
        end else begin : g_no_unit
            assign ud_next = ud_i;
            assign up_next = up_i;
            assign k_next  = k_i;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            s_o    <= s_i;
            rd_o   <= rd_next;
            r_o    <= r_next;
            ud_o   <= ud_next;
            up_o   <= up_next;
            k_o    <= k_next;
            sign_o <= sign_i;
        end
    end

endmodule

FILE: design/vector3_normalizer.sv
// vector3_normalizer top level: magnitude and unit vector of a 3-component vector
// depends on vn_pkg, vn_front, vn_step
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   input   | s_valid s_ready s_x_in s_y_in s_z_in | in
//   result  | m_valid m_ready m_x_unit m_y_unit    | out
//           | m_z_unit m_magnitude m_zero_vector   |
//
// one item enters per cycle unless stalled; the pipeline holds the front end stages,
// one shift-add stage per root and unit bit position, and the output register
// the whole pipeline advances together whenever the output register is empty
// or being taken, so a stall freezes every stage in place
// aresetn (synchronous, active low) clears only the valid bits
// the magnitude keeps the components' fraction bits, so the binary point
// never enters the logic
module vector3_normalizer
    import vn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COMPONENT_WIDTH-1:0] s_x_in,
    input  logic signed [COMPONENT_WIDTH-1:0] s_y_in,
    input  logic signed [COMPONENT_WIDTH-1:0] s_z_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [UNIT_WIDTH-1:0]      m_x_unit,
    output logic signed [UNIT_WIDTH-1:0]      m_y_unit,
    output logic signed [UNIT_WIDTH-1:0]      m_z_unit,
    output logic [COMPONENT_WIDTH+1:0]        m_magnitude,
    output logic                              m_zero_vector
);

    localparam int CW  = COMPONENT_WIDTH;
    localparam int SW  = 2*CW + 2;
    localparam int MW  = CW + 2;
    localparam int UDW = 2*CW + 59;
    localparam int PW  = 2*CW + 33;
    localparam int NS  = (MW > KW) ? MW : KW;
    // front end stages, bit stages, output register
    localparam int LAT = 3 + NS + 1;

    logic           en;
    logic [LAT-1:0] v_reg;
    logic [LAT-1:0] v_next;

    // stage 0 of these arrays is the front end output
    logic [SW-1:0]   s_st  [NS+1];
    logic [SW-1:0]   rd_st [NS+1];
    logic [MW-1:0]   r_st  [NS+1];
    logic [UDW-1:0]  ud_st [NS+1][3];
    logic [PW-1:0]   up_st [NS+1][3];
    logic [KW-1:0]   k_st  [NS+1][3];
    logic [2:0]      sg_st [NS+1];
    logic [2*CW-1:0] sq    [3];

    logic [UNIT_WIDTH-1:0] unit_next [3];
    logic [UNIT_WIDTH-1:0] unit_reg  [3];
    logic [MW-1:0]         mag_reg;
    logic                  zero_reg;
    logic                  zero_next;

    // advance when the output slot is free or being drained
    assign en      = ~v_reg[LAT-1] | m_ready;
    assign s_ready = en;
    assign v_next  = {v_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    vn_front #(.CW(CW)) u_front (
        .aclk   (aclk),
        .en     (en),
        .x_in   (s_x_in),
        .y_in   (s_y_in),
        .z_in   (s_z_in),
        .sum_sq (s_st[0]),
        .sq     (sq),
        .sign   (sg_st[0])
    );

    // seed the iterations: root remainder is s, unit bound is a^2 * 2^60
    assign rd_st[0] = s_st[0];
    assign r_st[0]  = '0;
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            ud_st[0][j] = UDW'(sq[j]) << (2 * UNIT_FRAC);
            up_st[0][j] = '0;
            k_st[0][j]  = '0;
        end
    end

    // stage i resolves bit NS-1-i of the root and of each unit component, where that bit exists
    generate
        for (genvar i = 0; i < NS; i++) begin : g_stage
            vn_step #(.CW(CW), .B(NS - 1 - i)) u_step (
                .aclk   (aclk),
                .en     (en),
                .s_i    (s_st[i]),
                .rd_i   (rd_st[i]),
                .r_i    (r_st[i]),
                .ud_i   (ud_st[i]),
                .up_i   (up_st[i]),
                .k_i    (k_st[i]),
                .sign_i (sg_st[i]),
                .s_o    (s_st[i+1]),
                .rd_o   (rd_st[i+1]),
                .r_o    (r_st[i+1]),
                .ud_o   (ud_st[i+1]),
                .up_o   (up_st[i+1]),
                .k_o    (k_st[i+1]),
                .sign_o (sg_st[i+1])
            );
        end
    endgenerate

    // apply signs; a zero vector forces zero components
    always_comb begin
        zero_next = (s_st[NS] == '0);
        for (int j = 0; j < 3; j++) begin
            if (zero_next) begin
                unit_next[j] = '0;
            end else if (sg_st[NS][j]) begin
                unit_next[j] = -UNIT_WIDTH'(k_st[NS][j]);
            end else begin
                unit_next[j] = UNIT_WIDTH'(k_st[NS][j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            unit_reg <= unit_next;
            mag_reg  <= r_st[NS];
            zero_reg <= zero_next;
        end
    end

    assign m_valid       = v_reg[LAT-1];
    assign m_x_unit      = unit_reg[0];
    assign m_y_unit      = unit_reg[1];
    assign m_z_unit      = unit_reg[2];
    assign m_magnitude   = mag_reg;
    assign m_zero_vector = zero_reg;

endmodule
